### src/wbps_pkg.sv
// shared types and constants for the wildcard byte pattern scanner
// no dependencies; imported by every module of the block
package wbps_pkg;

    localparam int PATTERN_MAX_DEF = 32;

    // configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_SECOND = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_THIRD  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD_MASK  = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS   = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_LIMIT    = 4'd7;

    // field widths
    localparam int REG_PATTERN_BYTES = 32;
    localparam int PLEN_W            = 6;
    localparam int ADDR_W            = 64;
    localparam int COUNT_W           = 16;
    localparam int OUT_DATA_W        = 88;

    // control handed to every cell of the window chain
    typedef struct packed {
        logic shift;
        logic clear;
    } wbps_cell_ctrl_t;

    // one scanned byte leaving the cell row toward the result stage
    typedef struct packed {
        logic              hit;
        logic              last;
        logic [ADDR_W-1:0] off_adj;
    } wbps_item_t;

endpackage

### src/wbps_cell.sv
// one cell of the window chain: holds one window byte and its compare flag
// depends on wbps_pkg
module wbps_cell
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int IDX         = 0
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  wbps_cell_ctrl_t                     ctrl,
    input  logic [$clog2(PATTERN_MAX+1)-1:0]    len,
    input  logic [7:0]                          pat [PATTERN_MAX],
    input  logic [PATTERN_MAX-1:0]              wild,
    input  logic [7:0]                          byte_in,
    output logic [7:0]                          byte_out,
    output logic                                eq
);

    localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int PIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [7:0]        byte_reg;
    logic              eq_reg;
    logic              eq_next;
    logic              in_use;
    logic [LEN_W-1:0]  pos_full;
    logic [PIDX_W-1:0] pos;

    // this cell holds window byte IDX, which lines up with pattern byte len-1-IDX
    assign in_use   = len > LEN_W'(IDX);
    assign pos_full = len - LEN_W'(IDX + 1);
    assign pos      = pos_full[PIDX_W-1:0];
    assign eq_next  = !in_use || wild[pos] || (byte_in == pat[pos]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
            eq_reg   <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            byte_reg <= ctrl.clear ? 8'd0 : byte_in;
            eq_reg   <= eq_next;
        end
    end

    assign byte_out = byte_reg;
    assign eq       = eq_reg;

endmodule

### src/wbps_result.sv
// result stage: match count, limit check, address add and output register
// depends on wbps_pkg
module wbps_result
    import wbps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  wbps_item_t            item,
    input  logic [ADDR_W-1:0]     base,
    input  logic [COUNT_W-1:0]    limit,
    output logic                  out_free,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [COUNT_W-1:0] matches_reg;
    logic [COUNT_W-1:0] matches_next;
    logic [COUNT_W-1:0] number_next;
    logic               valid_reg;
    logic               valid_next;
    logic               report;
    logic [ADDR_W-1:0]  addr_reg;
    logic [COUNT_W-1:0] number_reg;
    logic               lim_reg;

    assign out_free    = !valid_reg || m_axis_tready;
    assign report      = take && item.hit && (matches_reg < limit);
    assign number_next = matches_reg + COUNT_W'(1);

    always_comb
    begin
        matches_next = matches_reg;
        if (take)
        begin
            if (item.last)
                matches_next = '0;
            else if (report)
                matches_next = number_next;
        end
        valid_next = valid_reg;
        if (report)
            valid_next = 1'b1;
        else if (m_axis_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matches_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            matches_reg <= matches_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (report)
        begin
            addr_reg   <= base + item.off_adj;
            number_reg <= number_next;
            lim_reg    <= (number_next == limit);
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {7'd0, lim_reg, number_reg, addr_reg};

endmodule

### src/wildcard_byte_pattern_scanner.sv
// top level of the wildcard byte pattern scanner: config registers, cell row
// depends on wbps_pkg, wbps_cell, wbps_result
//
// Scans a byte stream for a pattern of up to PATTERN_MAX bytes where bytes
// flagged in the wildcard mask match anything; every alignment is checked.
// Takes one byte per clock cycle without gaps while the result stream is
// ready. A match held on the output by m_axis_tready low stops the input
// once one more byte has entered the row of cells; s_axis_tready follows
// m_axis_tready within the same cycle. m_axis_tvalid for a match rises
// when the result stage registers it: the last byte of the match is first
// registered in the row of cells, where every cell compares its window
// byte to its pattern byte as the window shifts; the result stage, which
// counts matches and adds the base address, registers it when its output
// is free. Reporting stops at match_limit matches; tlast ends the region
// and clears the window and counters. Configuration writes are always taken
// and apply from the next byte.
module wildcard_byte_pattern_scanner
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // config write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
    input  logic                   s_axis_tlast,   // last_byte
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata    // [63:0] match_address,
                                                   // [79:64] match_number,
                                                   // [80] limit_reached
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic [REG_PATTERN_BYTES*8-1:0] pat_reg;
    logic [31:0]                    wild_reg;
    logic [PLEN_W-1:0]              plen_reg;
    logic [ADDR_W-1:0]              base_reg;
    logic [COUNT_W-1:0]             limit_reg;

    logic                           cfg_write;
    logic                           in_accept;
    logic [LEN_W-1:0]               len;
    logic [LEN_W-1:0]               seen_reg;
    logic [LEN_W-1:0]               seen_next;
    logic [LEN_W-1:0]               seen_inc;
    logic [ADDR_W-1:0]              offset_reg;
    logic [ADDR_W-1:0]              offset_next;

    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    logic                           s1_enough_reg;
    logic                           s1_last_reg;
    logic [ADDR_W-1:0]              s1_off_reg;

    logic                           adv;
    logic                           out_free;
    wbps_item_t                     item;
    wbps_cell_ctrl_t                cell_ctrl;

    logic [7:0]                     pat_arr [PATTERN_MAX];
    logic [7:0]                     chain [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]         eq_vec;

    // config registers
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg   <= '0;
            wild_reg  <= '0;
            plen_reg  <= PLEN_W'(1);
            base_reg  <= '0;
            limit_reg <= COUNT_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:    pat_reg[63:0]    <= cfg_data;
                REG_PATTERN_SECOND: pat_reg[127:64]  <= cfg_data;
                REG_PATTERN_THIRD:  pat_reg[191:128] <= cfg_data;
                REG_PATTERN_HIGH:   pat_reg[255:192] <= cfg_data;
                REG_WILDCARD_MASK:  wild_reg         <= cfg_data[31:0];
                REG_PATTERN_LENGTH: plen_reg         <= cfg_data[PLEN_W-1:0];
                REG_BASE_ADDRESS:   base_reg         <= cfg_data;
                REG_MATCH_LIMIT:    limit_reg        <= cfg_data[COUNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // active length: zero counts as one, clamp to the cell count
    always_comb
    begin
        priority if (plen_reg == '0)
            len = LEN_W'(1);
        else if (plen_reg > PLEN_W'(PATTERN_MAX))
            len = LEN_W'(PATTERN_MAX);
        else
            len = plen_reg[LEN_W-1:0];
    end

    // input side and region counters
    assign adv           = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign seen_inc      = (seen_reg == LEN_W'(PATTERN_MAX)) ? seen_reg
                                                             : seen_reg + LEN_W'(1);

    always_comb
    begin
        seen_next     = seen_reg;
        offset_next   = offset_reg;
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            seen_next     = s_axis_tlast ? '0 : seen_inc;
            offset_next   = s_axis_tlast ? '0 : offset_reg + ADDR_W'(1);
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            offset_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg     <= seen_next;
            offset_reg   <= offset_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_enough_reg <= seen_inc >= len;
            s1_last_reg   <= s_axis_tlast;
            s1_off_reg    <= offset_reg - ADDR_W'(len - LEN_W'(1));
        end
    end

    // row of window cells
    assign cell_ctrl.shift = in_accept;
    assign cell_ctrl.clear = s_axis_tlast;
    assign chain[0]        = s_axis_tdata;

    for (genvar i = 0; i < PATTERN_MAX; i++)
    begin : g_cell
        assign pat_arr[i] = pat_reg[8*i +: 8];

        if (i < PATTERN_MAX - 1)
        begin : g_mid
            wbps_cell #(
                .PATTERN_MAX (PATTERN_MAX),
                .IDX         (i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .len      (len),
                .pat      (pat_arr),
                .wild     (wild_reg[PATTERN_MAX-1:0]),
                .byte_in  (chain[i]),
                .byte_out (chain[i+1]),
                .eq       (eq_vec[i])
            );
        end
        else
        begin : g_end
            // oldest byte of the window is not passed on
            wbps_cell #(
                .PATTERN_MAX (PATTERN_MAX),
                .IDX         (i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .len      (len),
                .pat      (pat_arr),
                .wild     (wild_reg[PATTERN_MAX-1:0]),
                .byte_in  (chain[i]),
                .byte_out (),
                .eq       (eq_vec[i])
            );
        end
    end

    assign item.hit     = (&eq_vec) && s1_enough_reg;
    assign item.last    = s1_last_reg;
    assign item.off_adj = s1_off_reg;

    wbps_result u_result (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (adv),
        .item          (item),
        .base          (base_reg),
        .limit         (limit_reg),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
